>>> design/bounded_sequential_list_defines.svh
// Assertion macros used by the bounded sequential list top module.
`ifndef BOUNDED_SEQUENTIAL_LIST_DEFINES_SVH
`define BOUNDED_SEQUENTIAL_LIST_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define BSL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define BSL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> design/bsl_pkg.sv
// Package with the constants and types of the bounded sequential list.
package bsl_pkg;

  localparam int unsigned Capacity = 32;
  localparam int unsigned CntW     = $clog2(Capacity);
  localparam int unsigned DataW    = 32;
  localparam int unsigned CountW   = 5;

  typedef enum logic [2:0] {
    OpInsFront = 3'd0,
    OpInsBack  = 3'd1,
    OpRemFront = 3'd2,
    OpRemBack  = 3'd3,
    OpSearch   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    StIdle,
    StReduce,
    StRespond
  } state_e;

  // Per-cell load and compare strobes.
  typedef struct packed {
    logic load_value;
    logic load_left;
    logic load_right;
    logic compare;
  } cell_ctrl_t;

endpackage

>>> design/bsl_cell.sv
// One storage cell of the list: holds an entry and compares it on search.
module bsl_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bsl_pkg::cell_ctrl_t         ctrl_i,
  input  logic [bsl_pkg::DataW-1:0]   value_i,
  input  logic [bsl_pkg::DataW-1:0]   left_i,
  input  logic [bsl_pkg::DataW-1:0]   right_i,
  output logic [bsl_pkg::DataW-1:0]   entry_o,
  output logic                        match_o
);
  import bsl_pkg::*;

  logic [DataW-1:0] entry_q;
  logic             match_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_value) begin
      entry_q <= value_i;
    end else if (ctrl_i.load_left) begin
      entry_q <= left_i;
    end else if (ctrl_i.load_right) begin
      entry_q <= right_i;
    end
  end

  // The match uses the entry as stored before this request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= ctrl_i.compare && (entry_q == value_i);
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

>>> design/bounded_sequential_list.sv
// A request is accepted in StIdle; the cells register their match bits, StReduce
// registers their OR into found, and StRespond shows the result until out_ready_i
// takes it, so no new request is accepted before then. Shifts happen in all cells at
// once, and a back insert loads only the cell at the count, both in the accept cycle.
// Reset clears the count and the handshake state; entry contents stay undefined.
module bounded_sequential_list (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                operation_i,
  input  logic signed [31:0]        value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      ok_o,
  output logic                      found_o,
  output logic [4:0]                count_o
);
  import bsl_pkg::*;
  `include "bounded_sequential_list_defines.svh"

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic ok_q, ok_d;
  logic found_q;

  logic accept;
  logic not_full;
  logic not_empty;
  logic ins_front_go, ins_back_go, rem_front_go, search_go;

  logic [DataW-1:0] entry  [Capacity];
  logic [Capacity-1:0] match;
  cell_ctrl_t ctrl [Capacity];

  logic [CntW+CountW-1:0] count_ext;

  assign accept    = in_valid_i && in_ready_o;
  assign not_full  = count_q < CntW'(Capacity - 1);
  assign not_empty = count_q != '0;

  always_comb begin
    count_d      = count_q;
    ok_d         = 1'b0;
    ins_front_go = 1'b0;
    ins_back_go  = 1'b0;
    rem_front_go = 1'b0;
    search_go    = 1'b0;
    if (accept) begin
      case (op_e'(operation_i))
        OpInsFront: begin
          if (not_full) begin
            ins_front_go = 1'b1;
            count_d      = count_q + CntW'(1);
            ok_d         = 1'b1;
          end
        end
        OpInsBack: begin
          if (not_full) begin
            ins_back_go = 1'b1;
            count_d     = count_q + CntW'(1);
            ok_d        = 1'b1;
          end
        end
        OpRemFront: begin
          if (not_empty) begin
            rem_front_go = 1'b1;
            count_d      = count_q - CntW'(1);
            ok_d         = 1'b1;
          end
        end
        OpRemBack: begin
          if (not_empty) begin
            count_d = count_q - CntW'(1);
            ok_d    = 1'b1;
          end
        end
        OpSearch: begin
          search_go = 1'b1;
          ok_d      = 1'b1;
        end
        default: begin
          ok_d = 1'b0;
        end
      endcase
    end
  end

  // Cell 0 takes the new value on a front insert; the last cell keeps its own entry
  // on a front remove.
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic [DataW-1:0] left, right;

    if (i == 0) begin : g_first
      assign left = value_i;
    end else begin : g_left
      assign left = entry[i-1];
    end
    if (i == Capacity - 1) begin : g_last
      assign right = entry[i];
    end else begin : g_right
      assign right = entry[i+1];
    end

    assign ctrl[i].load_value = ins_back_go && (count_q == CntW'(i));
    assign ctrl[i].load_left  = ins_front_go;
    assign ctrl[i].load_right = rem_front_go;
    assign ctrl[i].compare    = search_go && (CntW'(i) < count_q);

    bsl_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl[i]),
      .value_i (value_i),
      .left_i  (left),
      .right_i (right),
      .entry_o (entry[i]),
      .match_o (match[i])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StReduce;
        end
      end
      StReduce: begin
        state_d = StRespond;
      end
      StRespond: begin
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle:    in_ready_o  = 1'b1;
      StRespond: out_valid_o = 1'b1;
      default: begin
        in_ready_o  = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      ok_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (accept) begin
        ok_q <= ok_d;
      end
      if (state_q == StReduce) begin
        found_q <= |match;
      end
    end
  end

  assign count_ext = {{CountW{1'b0}}, count_q};
  assign ok_o      = ok_q;
  assign found_o   = found_q;
  assign count_o   = count_ext[CountW-1:0];

  `BSL_ASSERT_IMP(a_found_implies_ok, out_valid_o && found_o, ok_o)
  `BSL_ASSERT_IMP(a_no_accept_while_busy, out_valid_o, !in_ready_o)
  `BSL_ASSERT_NXT(a_reject_keeps_count, accept && !ok_d, count_q == $past(count_q))
  `BSL_ASSERT_NXT(a_front_insert_counts,
                  ins_front_go, count_q == $past(count_q) + CntW'(1))
  `BSL_ASSERT_NXT(a_result_after_reduce, state_q == StReduce, out_valid_o)

endmodule

>>> verif/bounded_sequential_list_checker.sv
`timescale 1ns / 1ps
// Checker for the bounded sequential list: predicts every result and compares it.
module bounded_sequential_list_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [2:0]                        operation_i,
  input  logic signed [bsl_pkg::DataW-1:0]  value_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic                              ok_i,
  input  logic                              found_i,
  input  logic [bsl_pkg::CountW-1:0]        count_i,
  output int                                fail_cnt_o,
  output int                                pending_o,
  output int                                checked_o,
  output int                                full_refused_o,
  output int                                empty_refused_o,
  output int                                search_hits_o
);
  import bsl_pkg::*;

  typedef struct packed {
    logic              ok;
    logic              found;
    logic [CountW-1:0] count;
  } list_result_t;

  logic signed [DataW-1:0] list_shadow[$];
  list_result_t            expected_results[$];

  assign pending_o = expected_results.size();

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] MISMATCH on result %0d: %s is %0d, expected %0d",
             $realtime, checked_o, field, got, want);
    fail_cnt_o++;
  endtask

  // Applies one request to the shadow list and returns the result it causes.
  function automatic list_result_t apply_request(input logic [2:0] operation,
                                                 input logic signed [DataW-1:0] value);
    list_result_t res;
    res = '0;
    case (operation)
      OpInsFront, OpInsBack: begin
        if (list_shadow.size() < Capacity - 1) begin
          if (operation == OpInsFront) list_shadow.push_front(value);
          else list_shadow.push_back(value);
          res.ok = 1'b1;
        end
      end
      OpRemFront: begin
        if (list_shadow.size() > 0) begin
          void'(list_shadow.pop_front());
          res.ok = 1'b1;
        end
      end
      OpRemBack: begin
        if (list_shadow.size() > 0) begin
          void'(list_shadow.pop_back());
          res.ok = 1'b1;
        end
      end
      OpSearch: begin
        res.ok = 1'b1;
        foreach (list_shadow[i]) if (list_shadow[i] == value) res.found = 1'b1;
      end
      default: ;
    endcase
    res.count = CountW'(list_shadow.size());
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t res;
    list_result_t want;
    if (!rst_ni) begin
      list_shadow.delete();
      expected_results.delete();
      fail_cnt_o      <= 0;
      checked_o       <= 0;
      full_refused_o  <= 0;
      empty_refused_o <= 0;
      search_hits_o   <= 0;
    end else begin
      // The result is checked before the request of the same edge is predicted,
      // since a result never belongs to a request accepted at the same edge.
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("[%0t] MISMATCH: result with no request waiting", $realtime);
          fail_cnt_o++;
        end else begin
          want = expected_results.pop_front();
          if (ok_i !== want.ok) report_mismatch("ok", ok_i, want.ok);
          if (found_i !== want.found) report_mismatch("found", found_i, want.found);
          if (count_i !== want.count) report_mismatch("count", count_i, want.count);
        end
        checked_o++;
      end
      if (in_valid_i && in_ready_i) begin
        res = apply_request(operation_i, value_i);
        expected_results.push_back(res);
        if ((operation_i == OpInsFront || operation_i == OpInsBack) && !res.ok)
          full_refused_o++;
        if ((operation_i == OpRemFront || operation_i == OpRemBack) && !res.ok)
          empty_refused_o++;
        if (res.found) search_hits_o++;
      end
    end
  end

endmodule

>>> verif/bounded_sequential_list_tb.sv
`timescale 1ns / 1ps
// Testbench top for the bounded sequential list: clock, reset, request stimulus and verdict.
module bounded_sequential_list_tb;
  import bsl_pkg::*;

  localparam int RandomItems = 1350;
  localparam int CycleLimit  = 400000;
  localparam int HoldCycles  = 200;

  typedef enum int {PhFill, PhDrain, PhMixed, PhSearch} phase_e;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [2:0]              operation_i;
  logic signed [DataW-1:0] value_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic                    ok_o;
  logic                    found_o;
  logic [CountW-1:0]       count_o;

  int fail_cnt;
  int pending;
  int checked;
  int full_refused;
  int empty_refused;
  int search_hits;
  int requests_sent;
  int cycle_cnt;

  // A small pool of values makes searches hit stored entries often.
  logic signed [DataW-1:0] value_pool[12] = '{
    32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'shFFFF_FFFF,
    32'sh0000_0001, 32'shAAAA_AAAA, 32'sh5555_5555, 32'sh0000_0010,
    32'sh1234_5678, 32'shFFFF_0000, 32'sh8000_0001, 32'sh0000_FFFF
  };

  bounded_sequential_list dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .operation_i(operation_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .ok_o       (ok_o),
    .found_o    (found_o),
    .count_o    (count_o)
  );

  bounded_sequential_list_checker checker_inst (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .operation_i    (operation_i),
    .value_i        (value_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .ok_i           (ok_o),
    .found_i        (found_o),
    .count_i        (count_o),
    .fail_cnt_o     (fail_cnt),
    .pending_o      (pending),
    .checked_o      (checked),
    .full_refused_o (full_refused),
    .empty_refused_o(empty_refused),
    .search_hits_o  (search_hits)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_cnt, pending);
      $display("bounded_sequential_list verification failed");
      $finish;
    end
  end

  task automatic send_request(input logic [2:0] operation, input logic signed [DataW-1:0] value);
    in_valid_i  <= 1'b1;
    operation_i <= operation;
    value_i     <= value;
    do @(posedge clk_i); while (!in_ready_o);
    requests_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Always back to back in a burst; else mostly back to back, sometimes a few cycles, rarely a long gap.
  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(0, 9);
    if (burst || r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [DataW-1:0] pick_value();
    if ($urandom_range(0, 1)) return value_pool[$urandom_range(0, 11)];
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_operation(input phase_e kind);
    int ins_w;
    int rem_w;
    int r;
    case (kind)
      PhFill:  begin ins_w = 75; rem_w = 10; end
      PhDrain: begin ins_w = 10; rem_w = 75; end
      PhMixed: begin ins_w = 40; rem_w = 40; end
      default: begin ins_w = 25; rem_w = 25; end
    endcase
    // Codes above the search code are unused and must be ignored.
    if ($urandom_range(0, 99) < 3) return 3'(int'(OpSearch) + $urandom_range(1, 3));
    r = $urandom_range(0, 99);
    if (r < ins_w) return $urandom_range(0, 1) ? OpInsFront : OpInsBack;
    if (r < ins_w + rem_w) return $urandom_range(0, 1) ? OpRemFront : OpRemBack;
    return OpSearch;
  endfunction

  // Receiver: random stalls, calm stretches, and two long hold-offs while requests keep coming.
  initial begin
    int stall_left;
    int hold_left;
    int mode_left;
    int holds_done;
    bit steady;
    stall_left  = 0;
    hold_left   = 0;
    mode_left   = 0;
    holds_done  = 0;
    steady      = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        steady    = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      if (hold_left == 0 && holds_done < 2 && requests_sent >= 300 + 600 * holds_done) begin
        hold_left = HoldCycles;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 39) : $urandom_range(0, 2);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    phase_e kind;
    int     phase_len;
    int     random_sent;
    bit     burst;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    operation_i   = OpInsFront;
    value_i       = '0;
    requests_sent = 0;
    cycle_cnt     = 0;
    random_sent   = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty list, extreme values at both ends, hits and misses, unused codes.
    send_request(OpSearch, 32'sh0000_0000);
    send_request(OpRemFront, 32'sh7FFF_FFFF);
    send_request(OpRemBack, 32'sh8000_0000);
    send_request(OpInsFront, 32'sh8000_0000);
    send_request(OpInsBack, 32'sh7FFF_FFFF);
    pause_sender(3);
    send_request(OpInsFront, 32'sh0000_0000);
    send_request(OpInsBack, 32'shFFFF_FFFF);
    send_request(OpInsFront, 32'sh0000_0001);
    send_request(OpSearch, 32'sh8000_0000);
    send_request(OpSearch, 32'sh7FFF_FFFF);
    send_request(OpSearch, 32'shFFFF_FFFF);
    send_request(OpSearch, 32'sh1234_5678);
    send_request(OpRemFront, 32'sh0000_0000);
    send_request(OpSearch, 32'sh0000_0001);
    send_request(OpRemBack, 32'sh0000_0000);
    send_request(OpSearch, 32'shFFFF_FFFF);
    send_request(3'(int'(OpSearch) + 1), 32'sh5555_5555);
    send_request(3'(int'(OpSearch) + 2), 32'shAAAA_AAAA);
    send_request(3'(int'(OpSearch) + 3), 32'shFFFF_FFFF);
    send_request(OpInsBack, 32'sh5555_5555);
    send_request(OpInsFront, 32'shAAAA_AAAA);
    send_request(OpSearch, 32'shAAAA_AAAA);
    send_request(OpRemFront, 32'sh0000_0000);
    send_request(OpRemBack, 32'sh0000_0000);

    // Random phases: filling runs push the list toward full, draining runs toward empty.
    while (random_sent < RandomItems) begin
      kind      = phase_e'($urandom_range(0, 3));
      phase_len = $urandom_range(20, 70);
      burst     = ($urandom_range(0, 4) == 0);
      for (int j = 0; j < phase_len && random_sent < RandomItems; j++) begin
        send_request(pick_operation(kind), pick_value());
        random_sent++;
        pause_sender(pick_gap(burst));
      end
    end
    in_valid_i <= 1'b0;

    // Wait until every accepted request has had its result checked.
    while (checked < requests_sent) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d requests and checked %0d results against the shadow list.",
             requests_sent, checked);
    $display("Inserts refused when full: %0d, removals refused when empty: %0d, hits: %0d.",
             full_refused, empty_refused, search_hits);
    if (fail_cnt == 0) begin
      $display("bounded_sequential_list verification clean");
    end else begin
      $display("bounded_sequential_list verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/bsl_pkg.sv
design/bsl_cell.sv
design/bounded_sequential_list.sv
verif/bounded_sequential_list_checker.sv
verif/bounded_sequential_list_tb.sv
